### hdl/sin_pkg.sv
package sin_pkg;

    // result error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_INDEX = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    // open-ended range markers
    localparam logic [31:0] OPEN_START = 32'h8000_0000;
    localparam logic [31:0] OPEN_END   = 32'h7FFF_FFFF;

    // divider pipeline shape: quotient bits resolved per stage, and stage count
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = 8;

    // one transaction as it moves down the pipeline
    typedef struct packed {
        logic        valid;
        logic        remove;
        logic [1:0]  err;
        logic [30:0] first;
        logic [31:0] stride;
        logic [30:0] len;
        logic        need_div;
        logic [31:0] mag;
        logic [31:0] rem;
        logic [31:0] dvd;
        logic [31:0] quo;
    } t_pipe;

endpackage

### hdl/slice_index_normalizer_core.sv
// Slice index normaliser: one axis descriptor per transaction.
// Input: an item is taken at a rising edge where start is high and busy is
// low. busy is held low, so a descriptor may be issued on every cycle.
// Output: each result sits on the o_ ports for one cycle with o_valid high.
// Path from the accepting edge to the cycle with o_valid:
//   the decode (bounds, span and step magnitude) is registered at the
//   accepting edge itself,
//   the stages of a pipelined restoring divider resolve 4 quotient bits each
//   (ceiling length = floor((span - 1) / |step|) + 1),
//   and an output register holds the result.
// Throughput: one descriptor per cycle, set by the fully pipelined divider.
// Reset: synchronous, active low; clears all valid bits, so no result
// emerges from items in flight. Payload registers are not reset.
// The receiver cannot stall: results are emitted unconditionally.
module slice_index_normalizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_has_index,
    input  logic [31:0] i_range_start,
    input  logic [31:0] i_range_finish,
    input  logic [31:0] i_range_step,
    input  logic [30:0] i_axis_length,
    output logic        o_valid,
    output logic        o_drop_axis,
    output logic [30:0] o_first_index,
    output logic [31:0] o_index_stride,
    output logic [30:0] o_result_length,
    output logic [1:0]  o_error_code
);

    sin_pkg::t_pipe r_pipe [0:sin_pkg::DIV_STAGES];
    sin_pkg::t_pipe n_dec;

    assign busy = 1'b0;

    // decode: normalise start and finish, form span and step magnitude
    always_comb begin
        logic signed [33:0] n, s, e, st, en, size;
        logic               bad, pos;
        n    = $signed({3'b000, i_axis_length});
        s    = $signed({{2{i_range_start[31]}}, i_range_start});
        e    = $signed({{2{i_range_finish[31]}}, i_range_finish});
        st   = '0;
        en   = '0;
        size = '0;
        bad  = 1'b0;
        pos  = !i_range_step[31];
        n_dec          = '0;
        n_dec.valid    = start && !busy;
        n_dec.stride   = 32'd1;
        if (!i_has_index) begin
            n_dec.len = i_axis_length;
        end else if (i_range_step == 32'd0) begin
            n_dec.stride = 32'd0;
            if (s >= 0 && s < n) begin
                n_dec.remove = 1'b1;
                n_dec.first  = s[30:0];
                n_dec.len    = 31'd1;
            end else if (s < 0 && s >= -n) begin
                st           = s + n;
                n_dec.remove = 1'b1;
                n_dec.first  = st[30:0];
                n_dec.len    = 31'd1;
            end else begin
                n_dec.err = sin_pkg::ERR_INDEX;
            end
        end else begin
            // start bound
            if (s >= 0) begin
                if (s >= n) bad = 1'b1;
                else        st = s;
            end else if (s >= -n) begin
                st = s + n;
            end else if (i_range_start == sin_pkg::OPEN_START) begin
                st = pos ? 34'sd0 : n - 34'sd1;
            end else begin
                bad = 1'b1;
            end
            // finish bound
            if (e >= 0) begin
                if (pos ? (e <= n) : (e < n)) en = e;
                else if (i_range_finish == sin_pkg::OPEN_END) en = pos ? n : -34'sd1;
                else bad = 1'b1;
            end else if (e >= -n) begin
                en = e + n;
            end else begin
                bad = 1'b1;
            end
            size = pos ? (en - st) : (st - en);
            if (bad) begin
                n_dec.stride = 32'd0;
                n_dec.err    = sin_pkg::ERR_RANGE;
            end else if (size > 0) begin
                n_dec.need_div = 1'b1;
                n_dec.first    = st[30:0];
                n_dec.stride   = i_range_step;
                n_dec.mag      = pos ? i_range_step : (32'd0 - i_range_step);
                n_dec.dvd      = {1'b0, 31'(size - 34'sd1)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pipe[0].valid <= 1'b0;
        else          r_pipe[0].valid <= n_dec.valid;
        {r_pipe[0].remove, r_pipe[0].err, r_pipe[0].first, r_pipe[0].stride,
         r_pipe[0].len, r_pipe[0].need_div, r_pipe[0].mag, r_pipe[0].rem,
         r_pipe[0].dvd, r_pipe[0].quo} <=
        {n_dec.remove, n_dec.err, n_dec.first, n_dec.stride, n_dec.len,
         n_dec.need_div, n_dec.mag, n_dec.rem, n_dec.dvd, n_dec.quo};
    end

    // divider stages: each resolves BITS_PER_STAGE quotient bits
    for (genvar g = 0; g < sin_pkg::DIV_STAGES; g++) begin : g_div
        sin_pkg::t_pipe n_stg;
        always_comb begin
            logic [32:0] trial;
            n_stg = r_pipe[g];
            for (int b = 0; b < sin_pkg::BITS_PER_STAGE; b++) begin
                trial     = {n_stg.rem, n_stg.dvd[31]};
                n_stg.dvd = {n_stg.dvd[30:0], 1'b0};
                if (trial >= {1'b0, n_stg.mag}) begin
                    n_stg.rem = 32'(trial - {1'b0, n_stg.mag});
                    n_stg.quo = {n_stg.quo[30:0], 1'b1};
                end else begin
                    n_stg.rem = trial[31:0];
                    n_stg.quo = {n_stg.quo[30:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_pipe[g+1].valid <= 1'b0;
            else          r_pipe[g+1].valid <= n_stg.valid;
            {r_pipe[g+1].remove, r_pipe[g+1].err, r_pipe[g+1].first,
             r_pipe[g+1].stride, r_pipe[g+1].len, r_pipe[g+1].need_div,
             r_pipe[g+1].mag, r_pipe[g+1].rem, r_pipe[g+1].dvd, r_pipe[g+1].quo} <=
            {n_stg.remove, n_stg.err, n_stg.first, n_stg.stride, n_stg.len,
             n_stg.need_div, n_stg.mag, n_stg.rem, n_stg.dvd, n_stg.quo};
        end
    end

    // output register: ceiling length from floor quotient
    sin_pkg::t_pipe r_last;
    logic [31:0]    n_len;
    assign r_last = r_pipe[sin_pkg::DIV_STAGES];
    assign n_len  = r_last.quo + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_last.valid;
        o_drop_axis     <= r_last.remove;
        o_first_index   <= r_last.first;
        o_index_stride  <= r_last.stride;
        o_result_length <= r_last.need_div ? n_len[30:0] : r_last.len;
        o_error_code    <= r_last.err;
    end

`ifndef ASSERT_OFF
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != sin_pkg::ERR_NONE |->
        !o_drop_axis && o_result_length == 31'd0 && o_first_index == 31'd0)
        else $error("error result carries payload");
    a_remove_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drop_axis |-> o_result_length == 31'd1 && o_index_stride == 32'd0)
        else $error("removed axis without single element");
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last.valid |=> o_valid)
        else $error("divider output lost");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe[0].valid && r_pipe[0].need_div |-> r_pipe[0].mag != 32'd0)
        else $error("division by zero step");
`endif

endmodule
